@@ rtl/ffa_pkg.sv @@
// Shared constants, opcodes and control types for the first-fit heap allocator.
// No dependencies; every other file imports this package.
package ffa_pkg;

    localparam int HEAP_UNITS_DEF = 4096;
    localparam int UNIT_BYTES     = 8;
    localparam int UNIT_SHIFT     = $clog2(UNIT_BYTES);
    localparam int HEADER_UNITS   = 2;

    localparam int OP_W    = 2;
    localparam int BYTES_W = 16;
    localparam int OFF_W   = 15;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_RESIZE  = 2'd2;

    typedef struct packed {
        logic neg_b;
        logic add_hdr;
        logic sub_hdr;
    } t_alu_ctl;

endpackage

@@ rtl/ffa_alu.sv @@
// Shared add / subtract / compare unit of the allocator sequencer.
// Depends on ffa_pkg for the header size and the control struct.
module ffa_alu import ffa_pkg::*; #(
    parameter int CW = 18
) (
    input  logic [CW-1:0] i_a,
    input  logic [CW-1:0] i_b,
    input  logic [CW-1:0] i_c,
    input  t_alu_ctl      i_ctl,
    output logic [CW-1:0] o_y,
    output logic          o_ge
);

    logic [CW-1:0] w_b;
    logic [CW-1:0] w_h;

    assign w_b  = i_ctl.neg_b ? (~i_b + 1'b1) : i_b;
    assign w_h  = i_ctl.add_hdr ? CW'(HEADER_UNITS) :
                  (i_ctl.sub_hdr ? (~CW'(HEADER_UNITS) + 1'b1) : '0);
    assign o_y  = i_a + w_b + w_h;
    assign o_ge = $signed(o_y) >= $signed(i_c);

endmodule

@@ rtl/ffa_hdr_ram.sv @@
// Block header store: one write port, one registered read port.
// Depends on ffa_pkg for HEAP_UNITS_DEF, which sets the default depth and widths.
module ffa_hdr_ram import ffa_pkg::*; #(
    parameter int DEPTH = HEAP_UNITS_DEF,
    parameter int AW    = $clog2(HEAP_UNITS_DEF),
    parameter int DW    = 3 + 2 * $clog2(HEAP_UNITS_DEF)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/first_fit_heap_allocator_unit.sv @@
// First-fit heap allocator: sequencer over a header store and one shared ALU.
// A first-fit search steps through S_AL, S_AL_CHK and S_AL_NX for each block it passes over;
// the result, once valid in S_OUT, then waits for i_stall low.
// Flow: one request in flight; the next transfer is taken in the cycle after the result is accepted.
// Reset: synchronous; a clearing pass then writes all HEAP_UNITS headers, input stalled.
module first_fit_heap_allocator_unit import ffa_pkg::*; #(
    parameter int HEAP_UNITS = HEAP_UNITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [OP_W-1:0]    i_op,
    input  logic [BYTES_W-1:0] i_request_bytes,
    input  logic [OFF_W-1:0]   i_payload_offset,
    input  logic               i_payload_null,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [OFF_W-1:0]   o_result_offset,
    output logic               o_result_null,
    output logic               o_copy_needed,
    output logic [BYTES_W-1:0] o_copy_bytes
);

    localparam int AW = $clog2(HEAP_UNITS);
    localparam int CW = ((AW > 16) ? AW : 16) + 2;

    typedef struct packed {
        logic          valid;
        logic          free;
        logic          has_prev;
        logic [AW-1:0] size;
        logic [AW-1:0] prev;
    } t_hdr;

    localparam int DW = $bits(t_hdr);

    typedef enum logic [26:0] {
        S_CLR      = 27'h0000001,
        S_IDLE     = 27'h0000002,
        S_WANT     = 27'h0000004,
        S_DEC0     = 27'h0000008,
        S_DEC1     = 27'h0000010,
        S_DEC2     = 27'h0000020,
        S_GROW     = 27'h0000040,
        S_GROW_CHK = 27'h0000080,
        S_AL       = 27'h0000100,
        S_AL_CHK   = 27'h0000200,
        S_AL_NX    = 27'h0000400,
        S_SP       = 27'h0000800,
        S_SP_T     = 27'h0001000,
        S_SP_NN0   = 27'h0002000,
        S_SP_NN    = 27'h0004000,
        S_SP_WB    = 27'h0008000,
        S_MG       = 27'h0010000,
        S_MG_CHK   = 27'h0020000,
        S_MG_INV   = 27'h0040000,
        S_MG_NN    = 27'h0080000,
        S_RET      = 27'h0100000,
        S_REL_RD   = 27'h0200000,
        S_REL_LD   = 27'h0400000,
        S_REL      = 27'h0800000,
        S_REL_P    = 27'h1000000,
        S_PUT      = 27'h2000000,
        S_OUT      = 27'h4000000
    } t_state;

    typedef enum logic [2:0] {
        RET_ALLOC,
        RET_SHRINK,
        RET_GROW,
        RET_PUT,
        RET_REL1,
        RET_DONE
    } t_ret;

    typedef enum logic [1:0] {
        PH_ALLOC,
        PH_REL,
        PH_RSZ,
        PH_MOVE
    } t_phase;

    t_state              r_state, n_state;
    t_ret                r_ret, n_ret;
    t_phase              r_phase, n_phase;
    logic [AW-1:0]       r_clr, n_clr;
    logic [OP_W-1:0]     r_op, n_op;
    logic [BYTES_W-1:0]  r_bytes, n_bytes;
    logic [OFF_W-1:0]    r_off, n_off;
    logic                r_pnull, n_pnull;
    logic [CW-1:0]       r_want, n_want;
    logic [CW-1:0]       r_y, n_y;
    logic [AW-1:0]       r_b, n_b;
    logic [AW-1:0]       r_n, n_n;
    logic [AW-1:0]       r_t, n_t;
    logic [AW-1:0]       r_ob, n_ob;
    logic [AW-1:0]       r_oldsz, n_oldsz;
    logic                r_t_ok, n_t_ok;
    t_hdr                r_hb, n_hb;
    t_hdr                r_hn, n_hn;
    t_hdr                r_ht, n_ht;
    logic [OFF_W-1:0]    r_res_off, n_res_off;
    logic                r_res_null, n_res_null;
    logic                r_copy, n_copy;
    logic [BYTES_W-1:0]  r_copy_bytes, n_copy_bytes;

    logic [CW-1:0]       alu_a, alu_b, alu_c, alu_y;
    logic                alu_ge;
    t_alu_ctl            alu_ctl;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [DW-1:0]       mem_wdata, mem_rdata;

    ffa_alu #(.CW(CW)) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_c   (alu_c),
        .i_ctl (alu_ctl),
        .o_y   (alu_y),
        .o_ge  (alu_ge)
    );

    ffa_hdr_ram #(.DEPTH(HEAP_UNITS), .AW(AW), .DW(DW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        t_hdr          rd;
        t_hdr          wr;
        logic [CW-1:0] sh;
        rd = t_hdr'(mem_rdata);
        wr = r_hb;
        sh = '0;

        n_state      = r_state;
        n_ret        = r_ret;
        n_phase      = r_phase;
        n_clr        = r_clr;
        n_op         = r_op;
        n_bytes      = r_bytes;
        n_off        = r_off;
        n_pnull      = r_pnull;
        n_want       = r_want;
        n_y          = r_y;
        n_b          = r_b;
        n_n          = r_n;
        n_t          = r_t;
        n_ob         = r_ob;
        n_oldsz      = r_oldsz;
        n_t_ok       = r_t_ok;
        n_hb         = r_hb;
        n_hn         = r_hn;
        n_ht         = r_ht;
        n_res_off    = r_res_off;
        n_res_null   = r_res_null;
        n_copy       = r_copy;
        n_copy_bytes = r_copy_bytes;

        alu_a   = '0;
        alu_b   = '0;
        alu_c   = '0;
        alu_ctl = '0;

        mem_we    = 1'b0;
        mem_waddr = r_b;
        mem_wdata = r_hb;
        mem_raddr = r_b;

        case (r_state)
            S_CLR: begin
                wr = '0;
                if (r_clr == '0) begin
                    wr.valid = 1'b1;
                    wr.free  = 1'b1;
                    wr.size  = AW'(HEAP_UNITS - HEADER_UNITS);
                end
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = wr;
                if (r_clr == AW'(HEAP_UNITS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_op         = i_op;
                    n_bytes      = i_request_bytes;
                    n_off        = i_payload_offset;
                    n_pnull      = i_payload_null;
                    n_res_off    = '0;
                    n_res_null   = 1'b1;
                    n_copy       = 1'b0;
                    n_copy_bytes = '0;
                    n_state      = S_WANT;
                end
            end
            S_WANT: begin
                alu_a  = CW'(r_bytes);
                alu_b  = CW'(UNIT_BYTES - 1);
                n_want = CW'(alu_y[CW-1:UNIT_SHIFT]);
                if (r_op == OP_ALLOC || (r_op == OP_RESIZE && r_pnull)) begin
                    if (r_bytes != '0) begin
                        n_phase = PH_ALLOC;
                        n_b     = '0;
                        n_state = S_AL;
                    end else begin
                        n_state = S_OUT;
                    end
                end else if (r_op == OP_RELEASE && !r_pnull) begin
                    n_phase = PH_REL;
                    n_state = S_DEC0;
                end else if (r_op == OP_RESIZE) begin
                    n_phase = PH_RSZ;
                    n_state = S_DEC0;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DEC0: begin
                alu_a           = CW'(r_off[OFF_W-1:UNIT_SHIFT]);
                alu_ctl.sub_hdr = 1'b1;
                n_y             = alu_y;
                if (r_off[UNIT_SHIFT-1:0] != '0 || !alu_ge) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_DEC1;
                end
            end
            S_DEC1: begin
                alu_a = r_y;
                alu_c = CW'(HEAP_UNITS);
                if (alu_ge) begin
                    n_state = S_OUT;
                end else begin
                    mem_raddr = r_y[AW-1:0];
                    n_b       = r_y[AW-1:0];
                    n_state   = S_DEC2;
                end
            end
            S_DEC2: begin
                alu_a         = CW'(rd.size);
                alu_b         = r_want;
                alu_ctl.neg_b = 1'b1;
                if (!rd.valid || rd.free) begin
                    n_state = S_OUT;
                end else begin
                    n_hb    = rd;
                    n_ob    = r_b;
                    n_oldsz = rd.size;
                    if (r_phase == PH_REL || r_bytes == '0) begin
                        n_phase = PH_REL;
                        n_state = S_REL;
                    end else if (alu_ge) begin
                        n_ret   = RET_SHRINK;
                        n_state = S_SP;
                    end else begin
                        n_state = S_GROW;
                    end
                end
            end
            S_GROW: begin
                alu_a           = CW'(r_b);
                alu_b           = CW'(r_hb.size);
                alu_ctl.add_hdr = 1'b1;
                alu_c           = CW'(HEAP_UNITS);
                if (alu_ge) begin
                    n_phase = PH_MOVE;
                    n_b     = '0;
                    n_state = S_AL;
                end else begin
                    mem_raddr = alu_y[AW-1:0];
                    n_n       = alu_y[AW-1:0];
                    n_state   = S_GROW_CHK;
                end
            end
            S_GROW_CHK: begin
                alu_a           = CW'(r_hb.size);
                alu_b           = CW'(rd.size);
                alu_ctl.add_hdr = 1'b1;
                alu_c           = r_want;
                if (rd.valid && rd.free && alu_ge) begin
                    n_ret   = RET_GROW;
                    n_state = S_MG;
                end else begin
                    n_phase = PH_MOVE;
                    n_b     = '0;
                    n_state = S_AL;
                end
            end
            S_AL: begin
                mem_raddr = r_b;
                n_state   = S_AL_CHK;
            end
            S_AL_CHK: begin
                n_hb          = rd;
                alu_a         = CW'(rd.size);
                alu_b         = r_want;
                alu_ctl.neg_b = 1'b1;
                if (!rd.valid) begin
                    n_state = S_OUT;
                end else if (rd.free && alu_ge) begin
                    n_ret   = RET_ALLOC;
                    n_state = S_SP;
                end else begin
                    n_state = S_AL_NX;
                end
            end
            S_AL_NX: begin
                alu_a           = CW'(r_b);
                alu_b           = CW'(r_hb.size);
                alu_ctl.add_hdr = 1'b1;
                alu_c           = CW'(HEAP_UNITS);
                if (alu_ge) begin
                    n_state = S_OUT;
                end else begin
                    n_b     = alu_y[AW-1:0];
                    n_state = S_AL;
                end
            end
            S_SP: begin
                alu_a           = CW'(r_hb.size);
                alu_b           = r_want;
                alu_ctl.neg_b   = 1'b1;
                alu_ctl.sub_hdr = 1'b1;
                alu_c           = CW'(2);
                n_y             = alu_y;
                if (alu_ge) begin
                    n_state = S_SP_T;
                end else begin
                    n_t_ok  = 1'b0;
                    n_state = S_SP_WB;
                end
            end
            S_SP_T: begin
                alu_a           = CW'(r_b);
                alu_b           = r_want;
                alu_ctl.add_hdr = 1'b1;
                wr.valid        = 1'b1;
                wr.free         = 1'b1;
                wr.has_prev     = 1'b1;
                wr.size         = r_y[AW-1:0];
                wr.prev         = r_b;
                mem_we          = 1'b1;
                mem_waddr       = alu_y[AW-1:0];
                mem_wdata       = wr;
                n_t             = alu_y[AW-1:0];
                n_ht            = wr;
                n_t_ok          = 1'b1;
                n_state         = S_SP_NN0;
            end
            S_SP_NN0: begin
                alu_a           = CW'(r_b);
                alu_b           = CW'(r_hb.size);
                alu_ctl.add_hdr = 1'b1;
                alu_c           = CW'(HEAP_UNITS);
                if (!alu_ge) begin
                    mem_raddr = alu_y[AW-1:0];
                    n_n       = alu_y[AW-1:0];
                    n_state   = S_SP_NN;
                end else begin
                    n_state = S_SP_WB;
                end
            end
            S_SP_NN: begin
                wr          = rd;
                wr.prev     = r_t;
                wr.has_prev = 1'b1;
                mem_we      = 1'b1;
                mem_waddr   = r_n;
                mem_wdata   = wr;
                n_state     = S_SP_WB;
            end
            S_SP_WB: begin
                wr.free = 1'b0;
                if (r_t_ok) begin
                    wr.size = r_want[AW-1:0];
                end
                mem_we    = 1'b1;
                mem_wdata = wr;
                n_hb      = wr;
                n_state   = S_RET;
            end
            S_MG: begin
                alu_a           = CW'(r_b);
                alu_b           = CW'(r_hb.size);
                alu_ctl.add_hdr = 1'b1;
                alu_c           = CW'(HEAP_UNITS);
                if (alu_ge) begin
                    n_state = S_RET;
                end else begin
                    mem_raddr = alu_y[AW-1:0];
                    n_n       = alu_y[AW-1:0];
                    n_state   = S_MG_CHK;
                end
            end
            S_MG_CHK: begin
                alu_a           = CW'(r_hb.size);
                alu_b           = CW'(rd.size);
                alu_ctl.add_hdr = 1'b1;
                if (!rd.valid || !rd.free) begin
                    n_state = S_RET;
                end else begin
                    wr.size   = alu_y[AW-1:0];
                    mem_we    = 1'b1;
                    mem_wdata = wr;
                    n_hb      = wr;
                    n_hn      = rd;
                    n_state   = S_MG_INV;
                end
            end
            S_MG_INV: begin
                wr              = r_hn;
                wr.valid        = 1'b0;
                mem_we          = 1'b1;
                mem_waddr       = r_n;
                mem_wdata       = wr;
                alu_a           = CW'(r_b);
                alu_b           = CW'(r_hb.size);
                alu_ctl.add_hdr = 1'b1;
                alu_c           = CW'(HEAP_UNITS);
                if (!alu_ge) begin
                    mem_raddr = alu_y[AW-1:0];
                    n_n       = alu_y[AW-1:0];
                    n_state   = S_MG_NN;
                end else begin
                    n_state = S_RET;
                end
            end
            S_MG_NN: begin
                wr          = rd;
                wr.prev     = r_b;
                wr.has_prev = 1'b1;
                mem_we      = 1'b1;
                mem_waddr   = r_n;
                mem_wdata   = wr;
                n_state     = S_RET;
            end
            S_RET: begin
                case (r_ret)
                    RET_ALLOC, RET_SHRINK, RET_PUT: begin
                        n_state = S_PUT;
                    end
                    RET_GROW: begin
                        n_ret   = RET_PUT;
                        n_state = S_SP;
                    end
                    RET_REL1: begin
                        if (r_hb.has_prev) begin
                            mem_raddr = r_hb.prev;
                            n_state   = S_REL_P;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_REL_RD: begin
                mem_raddr = r_b;
                n_state   = S_REL_LD;
            end
            S_REL_LD: begin
                n_hb    = rd;
                n_state = S_REL;
            end
            S_REL: begin
                wr.free   = 1'b1;
                mem_we    = 1'b1;
                mem_wdata = wr;
                n_hb      = wr;
                n_ret     = RET_REL1;
                n_state   = S_MG;
            end
            S_REL_P: begin
                if (rd.valid && rd.free) begin
                    n_b     = r_hb.prev;
                    n_hb    = rd;
                    n_ret   = RET_DONE;
                    n_state = S_MG;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_PUT: begin
                alu_a           = CW'(r_b);
                alu_ctl.add_hdr = 1'b1;
                sh              = alu_y << UNIT_SHIFT;
                n_res_off       = sh[OFF_W-1:0];
                n_res_null      = 1'b0;
                if (r_phase == PH_MOVE) begin
                    sh           = CW'(r_oldsz) << UNIT_SHIFT;
                    n_copy       = 1'b1;
                    n_copy_bytes = sh[BYTES_W-1:0];
                    n_b          = r_ob;
                    n_state      = S_REL_RD;
                end else if (r_ret == RET_SHRINK && r_t_ok) begin
                    n_b     = r_t;
                    n_hb    = r_ht;
                    n_ret   = RET_DONE;
                    n_state = S_MG;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_ret   <= RET_DONE;
            r_phase <= PH_ALLOC;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ret   <= n_ret;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_bytes      <= n_bytes;
        r_off        <= n_off;
        r_pnull      <= n_pnull;
        r_want       <= n_want;
        r_y          <= n_y;
        r_b          <= n_b;
        r_n          <= n_n;
        r_t          <= n_t;
        r_ob         <= n_ob;
        r_oldsz      <= n_oldsz;
        r_t_ok       <= n_t_ok;
        r_hb         <= n_hb;
        r_hn         <= n_hn;
        r_ht         <= n_ht;
        r_res_off    <= n_res_off;
        r_res_null   <= n_res_null;
        r_copy       <= n_copy;
        r_copy_bytes <= n_copy_bytes;
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_result_offset = r_res_off;
    assign o_result_null   = r_res_null;
    assign o_copy_needed   = r_copy;
    assign o_copy_bytes    = r_copy_bytes;

`ifndef SYNTHESIS
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while a result is pending");

    a_null_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_null) |-> (o_result_offset == '0 && !o_copy_needed))
        else $error("null result carries an offset or copy");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_stall && !o_valid))
        else $error("clearing pass not entered after reset");
`endif

endmodule
